// ===== hw/rtl/aabbfc_pkg.sv =====
// Shared constants and types for the AABB frustum cull unit.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package aabbfc_pkg;

  localparam int FIELD_W = 32;  // width of every value field on the input word
  localparam int FRAC_W  = 16;  // Q16.16 fraction bits
  localparam int PIDX_W  = 3;
  localparam int CIDX_W  = 2;
  localparam int COEFFS  = 4;
  localparam int AXES    = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // slot of the constant term d; slots 0..2 are the x, y, z coefficients
  localparam logic [CIDX_W-1:0] COEFF_D = 2'd3;

  // load enables for the lane pipeline registers
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// ===== hw/rtl/aabbfc_if.sv =====
// Valid/ready channel interfaces for the cull unit: input word and result word.
// Depends on aabbfc_pkg for field widths.
`timescale 1ns / 1ps

interface aabbfc_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    operation;
  logic [aabbfc_pkg::PIDX_W-1:0]           plane_index;
  logic [aabbfc_pkg::CIDX_W-1:0]           coeff_index;
  logic signed [aabbfc_pkg::FIELD_W-1:0]   coeff_value;
  logic signed [aabbfc_pkg::FIELD_W-1:0]   box_min_x;
  logic signed [aabbfc_pkg::FIELD_W-1:0]   box_min_y;
  logic signed [aabbfc_pkg::FIELD_W-1:0]   box_min_z;
  logic signed [aabbfc_pkg::FIELD_W-1:0]   box_max_x;
  logic signed [aabbfc_pkg::FIELD_W-1:0]   box_max_y;
  logic signed [aabbfc_pkg::FIELD_W-1:0]   box_max_z;

  modport source (
    output valid, operation, plane_index, coeff_index, coeff_value,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );

  modport sink (
    input  valid, operation, plane_index, coeff_index, coeff_value,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface aabbfc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          visible;
  logic [aabbfc_pkg::PIDX_W-1:0] rejecting_plane;

  modport source (output valid, visible, rejecting_plane, input ready);
  modport sink   (input  valid, visible, rejecting_plane, output ready);
endinterface

// ===== hw/rtl/aabb_frustum_cull_test_unit.sv =====
// Top level of the AABB six-plane frustum cull unit.
// Depends on aabbfc_pkg, aabbfc_if, aabbfc_coef_tbl and aabbfc_lane.
//
// Use:
//   in_ch carries one word per handshake. operation = load writes one
//   coefficient (a, b, c or d) of one plane and yields no result; writes to a
//   plane past the table are dropped. operation = test brings a box as min and
//   max corners and yields exactly one word on out_ch: visible, and the first
//   plane that has all eight corners on its negative side (plane count, masked
//   to 3 bits, when visible).
//   A test sees every load accepted before it.
// Throughput: one word per cycle on in_ch, loads and tests alike, while out_ch is not stalled.
// Pipeline: from test acceptance to out_ch.valid a test passes the register
//   stages corner select, partial products, product combine, plane sum sign,
//   and the plane-priority encode into the output register.
// Reset: synchronous, active low; clears the coefficient table to zero and
//   empties the pipeline.
// Stall: while out_ch.ready is low, the result holds and the stages behind it
//   fill up; empty stages still take new words, so in_ch.ready drops only once
//   the pipeline is full.
`timescale 1ns / 1ps

module aabb_frustum_cull_test_unit #(
  parameter int PLANE_COUNT = 6,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  aabbfc_in_if.sink     in_ch,
  aabbfc_out_if.source  out_ch
);

  localparam int VW = VALUE_WIDTH;
  localparam int NA = aabbfc_pkg::AXES;

  // reduce the Q16.16 fields to the datapath width, two's complement
  logic [VW-1:0]         coef_fit;
  logic [NA-1:0][VW-1:0] box_lo, box_hi;

  assign coef_fit  = VW'(in_ch.coeff_value);
  assign box_lo[0] = VW'(in_ch.box_min_x);
  assign box_lo[1] = VW'(in_ch.box_min_y);
  assign box_lo[2] = VW'(in_ch.box_min_z);
  assign box_hi[0] = VW'(in_ch.box_max_x);
  assign box_hi[1] = VW'(in_ch.box_max_y);
  assign box_hi[2] = VW'(in_ch.box_max_z);

  // pipeline flow control
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_acc, test_acc, tbl_we, out_en;
  aabbfc_pkg::stage_en_t en;

  assign rdy5 = !out_v_r || out_ch.ready;
  assign rdy4 = !s4_v_r  || rdy5;
  assign rdy3 = !s3_v_r  || rdy4;
  assign rdy2 = !s2_v_r  || rdy3;
  assign rdy1 = !s1_v_r  || rdy2;

  assign in_ch.ready = rdy1;
  assign in_acc      = in_ch.valid && rdy1;
  assign test_acc    = in_acc && (in_ch.operation == aabbfc_pkg::OP_TEST);
  assign tbl_we      = in_acc && (in_ch.operation == aabbfc_pkg::OP_LOAD)
                       && (int'(in_ch.plane_index) < PLANE_COUNT);

  assign en.s1  = test_acc;
  assign en.s2  = rdy2 && s1_v_r;
  assign en.s3  = rdy3 && s2_v_r;
  assign en.s4  = rdy4 && s3_v_r;
  assign out_en = rdy5 && s4_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r  <= test_acc;
      if (rdy2) s2_v_r  <= s1_v_r;
      if (rdy3) s3_v_r  <= s2_v_r;
      if (rdy4) s4_v_r  <= s3_v_r;
      if (rdy5) out_v_r <= s4_v_r;
    end
  end

  // coefficient table, read at the acceptance of a test word
  logic [PLANE_COUNT-1:0][aabbfc_pkg::COEFFS-1:0][VW-1:0] coef;

  aabbfc_coef_tbl #(
    .PLANE_COUNT (PLANE_COUNT),
    .VALUE_WIDTH (VW)
  ) u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (tbl_we),
    .wr_plane (in_ch.plane_index),
    .wr_slot  (in_ch.coeff_index),
    .wr_data  (coef_fit),
    .coef_o   (coef)
  );

  logic [PLANE_COUNT-1:0] outside;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    aabbfc_lane #(
      .VALUE_WIDTH (VW)
    ) u_lane (
      .clk       (clk),
      .en        (en),
      .coef      (coef[p]),
      .box_lo    (box_lo),
      .box_hi    (box_hi),
      .outside_o (outside[p])
    );
  end

  // lowest rejecting plane wins
  logic                          vis_nxt, vis_r;
  logic [aabbfc_pkg::PIDX_W-1:0] rej_nxt, rej_r;

  always_comb begin
    vis_nxt = 1'b1;
    rej_nxt = aabbfc_pkg::PIDX_W'(PLANE_COUNT);
    for (int p = PLANE_COUNT - 1; p >= 0; p--) begin
      if (outside[p]) begin
        vis_nxt = 1'b0;
        rej_nxt = aabbfc_pkg::PIDX_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      vis_r <= vis_nxt;
      rej_r <= rej_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.visible         = vis_r;
  assign out_ch.rejecting_plane = rej_r;

endmodule

// ===== hw/rtl/aabbfc_coef_tbl.sv =====
// Plane coefficient table: one row of four coefficients per plane, cleared at reset.
// Depends on aabbfc_pkg.
`timescale 1ns / 1ps

module aabbfc_coef_tbl #(
  parameter int PLANE_COUNT = 6,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                                     clk,
  input  logic                                                     rst_n,
  input  logic                                                     we,
  input  logic [aabbfc_pkg::PIDX_W-1:0]                            wr_plane,
  input  logic [aabbfc_pkg::CIDX_W-1:0]                            wr_slot,
  input  logic [VALUE_WIDTH-1:0]                                   wr_data,
  output logic [PLANE_COUNT-1:0][aabbfc_pkg::COEFFS-1:0][VALUE_WIDTH-1:0] coef_o
);

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_row
    logic [aabbfc_pkg::COEFFS-1:0][VALUE_WIDTH-1:0] row_r;

    // writes to a plane beyond the table never match a row
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        row_r <= '0;
      end else if (we && (int'(wr_plane) == p)) begin
        row_r[wr_slot] <= wr_data;
      end
    end

    assign coef_o[p] = row_r;
  end

endmodule

// ===== hw/rtl/aabbfc_lane.sv =====
// One plane's datapath: corner select, split multiply, product combine, plane sum sign.
// Four register stages; depends on aabbfc_pkg.
`timescale 1ns / 1ps

module aabbfc_lane #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                               clk,
  input  aabbfc_pkg::stage_en_t                              en,
  input  logic [aabbfc_pkg::COEFFS-1:0][VALUE_WIDTH-1:0]     coef,
  input  logic [aabbfc_pkg::AXES-1:0][VALUE_WIDTH-1:0]       box_lo,
  input  logic [aabbfc_pkg::AXES-1:0][VALUE_WIDTH-1:0]       box_hi,
  output logic                                               outside_o
);

  localparam int VW      = VALUE_WIDTH;
  localparam int H       = (VW + 1) / 2;   // low half, unsigned
  localparam int HW      = VW - H;         // high half, signed
  localparam int PP_HH_W = 2 * HW;
  localparam int PP_X_W  = HW + H + 1;
  localparam int PP_LL_W = 2 * H;
  localparam int PROD_W  = 2 * VW;
  localparam int SUM_W   = 2 * VW + 2;
  localparam int NA      = aabbfc_pkg::AXES;

  // stage 1: coefficient and the corner coordinate that maximizes its term
  logic signed [VW-1:0] a_r   [NA];
  logic signed [VW-1:0] b_r   [NA];
  logic signed [VW-1:0] b_nxt [NA];
  logic signed [VW-1:0] d1_r, d2_r, d3_r;

  // the plane sum is separable per axis, so the largest corner value is the sum
  // of the per-axis maxima; a*x peaks at the larger x for a >= 0, else the smaller
  always_comb begin
    for (int k = 0; k < NA; k++) begin
      if (coef[k][VW-1]) begin
        b_nxt[k] = ($signed(box_hi[k]) > $signed(box_lo[k])) ? $signed(box_lo[k])
                                                               : $signed(box_hi[k]);
      end else begin
        b_nxt[k] = ($signed(box_hi[k]) > $signed(box_lo[k])) ? $signed(box_hi[k])
                                                               : $signed(box_lo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int k = 0; k < NA; k++) begin
        a_r[k] <= $signed(coef[k]);
        b_r[k] <= b_nxt[k];
      end
      d1_r <= $signed(coef[aabbfc_pkg::COEFF_D]);
    end
  end

  // stage 2: four half-width partial products per axis
  logic signed [PP_HH_W-1:0] pp_hh_r [NA], pp_hh_nxt [NA];
  logic signed [PP_X_W-1:0]  pp_hl_r [NA], pp_hl_nxt [NA];
  logic signed [PP_X_W-1:0]  pp_lh_r [NA], pp_lh_nxt [NA];
  logic        [PP_LL_W-1:0] pp_ll_r [NA], pp_ll_nxt [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      pp_hh_nxt[k] = $signed(a_r[k][VW-1:H]) * $signed(b_r[k][VW-1:H]);
      pp_hl_nxt[k] = $signed(a_r[k][VW-1:H]) * $signed({1'b0, b_r[k][H-1:0]});
      pp_lh_nxt[k] = $signed({1'b0, a_r[k][H-1:0]}) * $signed(b_r[k][VW-1:H]);
      pp_ll_nxt[k] = a_r[k][H-1:0] * b_r[k][H-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      pp_hh_r <= pp_hh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_ll_r <= pp_ll_nxt;
      d2_r    <= d1_r;
    end
  end

  // stage 3: exact Q32.32 products
  logic signed [PROD_W-1:0] prod_r [NA], prod_nxt [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      prod_nxt[k] = (PROD_W'(pp_hh_r[k]) << (2 * H))
                  + (PROD_W'(pp_hl_r[k]) << H)
                  + (PROD_W'(pp_lh_r[k]) << H)
                  + PROD_W'(pp_ll_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod_r <= prod_nxt;
      d3_r   <= d2_r;
    end
  end

  // stage 4: largest corner value, d aligned to Q32.32; negative means all outside
  logic [SUM_W-1:0] sum_nxt;
  logic             outside_r;

  assign sum_nxt = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2])
                 + (SUM_W'(d3_r) << aabbfc_pkg::FRAC_W);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      outside_r <= sum_nxt[SUM_W-1];
    end
  end

  assign outside_o = outside_r;

endmodule

// ===== hw/rtl/aabbfc_checker.sv =====
// Port-level checks for the cull unit, attached to the top level by bind.
// Depends on aabbfc_pkg and aabb_frustum_cull_test_unit.
`timescale 1ns / 1ps

module aabbfc_checker #(
  parameter int PLANE_COUNT = 6
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_visible,
  input logic [aabbfc_pkg::PIDX_W-1:0] out_rejecting_plane
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visible)
                                && $stable(out_rejecting_plane))
    else $error("result word changed while stalled");

  a_vis_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |->
      out_rejecting_plane == aabbfc_pkg::PIDX_W'(PLANE_COUNT))
    else $error("visible box without the none code");

  a_rej_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> int'(out_rejecting_plane) < PLANE_COUNT)
    else $error("rejecting plane outside the table");

  // a result appearing on an empty output comes from an accepted test word
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && in_ready && (in_operation == aabbfc_pkg::OP_TEST), 5))
    else $error("result without a matching test word");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result word right after reset");

endmodule

bind aabb_frustum_cull_test_unit aabbfc_checker #(
  .PLANE_COUNT (PLANE_COUNT)
) u_aabbfc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_operation        (in_ch.operation),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_visible         (out_ch.visible),
  .out_rejecting_plane (out_ch.rejecting_plane)
);
